>>> hw/rtl/tpd_pkg.sv
// ----------------------------------------------------------------------------
// tpd_pkg
// Shared sizes, codes and constants of the timed pulse dispatcher.
// ----------------------------------------------------------------------------
package tpd_pkg;

  // Block sizes
  localparam int unsigned CHANNELS    = 4;
  localparam int unsigned QUEUE_DEPTH = 64;
  localparam int unsigned WIDTH_BITS  = 16;

  // Derived widths
  localparam int unsigned CH_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned SLOT_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned STORE_DEPTH = CHANNELS * QUEUE_DEPTH;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
  localparam int unsigned ENTRY_W     = 64;

  // Clamp limit of a phase width and the all-channels-ready pattern
  localparam logic [15:0] PW_MAX    = 16'((32'd1 << WIDTH_BITS) - 32'd1);
  localparam logic [3:0]  ALL_READY = 4'((32'd1 << CHANNELS) - 32'd1);

  // Register reset values
  localparam logic [31:0] RESET_IDLE_TIMEOUT = 32'd30000000;
  localparam logic [31:0] RESET_MAX_LEAD     = 32'd1000000;

  // Register indexes
  localparam logic [1:0] REG_READY_MASK   = 2'd0;
  localparam logic [1:0] REG_IDLE_TIMEOUT = 2'd1;
  localparam logic [1:0] REG_MAX_LEAD     = 2'd2;

  // Input word kinds
  localparam logic KIND_ENQUEUE = 1'b0;
  localparam logic KIND_TICK    = 1'b1;

  // Result outcome codes
  typedef enum logic [2:0] {
    OUT_NONE      = 3'd0,
    OUT_EMIT      = 3'd1,
    OUT_DROP_NA   = 3'd2,
    OUT_DROP_FULL = 3'd3,
    OUT_ENQ       = 3'd4,
    OUT_REJECT    = 3'd5
  } outcome_e;

endpackage

>>> hw/rtl/tpd_ram.sv
// ----------------------------------------------------------------------------
// tpd_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module tpd_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> hw/rtl/timed_pulse_dispatcher.sv
// ----------------------------------------------------------------------------
// timed_pulse_dispatcher
// Per-channel FIFOs of timed pulses in one shared store, served by a tick.
// ----------------------------------------------------------------------------
//
//  Channel   | Ports                                            | Handshake
//  ----------+--------------------------------------------------+--------------------
//  command   | kind_i channel_i pos_width_i neg_width_i         | start_i & !busy_o
//            | release_time_i now_us_i fifo_full_mask_i         |
//            | zero_pending_mask_i                              |
//  result    | out_channel_o outcome_o pulse_word_o             | result_valid_o,
//            | drive_enable_o last_o                            | one cycle, no stall
//  config    | cfg_idx_i cfg_data_i                             | cfg_we_i
//
//  An enqueue word keeps busy_o high for one cycle and its result shows in
//  the cycle after that one. A tick keeps busy_o high while each channel in
//  turn is served: ST_RD reads its FIFO head from the store (one registered
//  read port) and ST_EV evaluates it.
//  A new word may be accepted in the cycle that shows the last result.
//  Reset empties all FIFOs and turns the drive off; the store is not cleared.
//
module timed_pulse_dispatcher (
  input  logic        clk_i,
  input  logic        rst_ni,
  // command
  input  logic        start_i,
  output logic        busy_o,
  input  logic        kind_i,
  input  logic [2:0]  channel_i,
  input  logic [15:0] pos_width_i,
  input  logic [15:0] neg_width_i,
  input  logic [31:0] release_time_i,
  input  logic [31:0] now_us_i,
  input  logic [3:0]  fifo_full_mask_i,
  input  logic [3:0]  zero_pending_mask_i,
  // configuration
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  // result
  output logic        result_valid_o,
  output logic [2:0]  out_channel_o,
  output logic [2:0]  outcome_o,
  output logic [31:0] pulse_word_o,
  output logic        drive_enable_o,
  output logic        last_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ENQ,
    ST_RD,
    ST_EV
  } state_e;

  state_e state_q;

  // Configuration registers
  logic [3:0]  ready_q;
  logic [31:0] timeout_q;
  logic [31:0] lead_q;

  // Latched command word
  logic [2:0]  ch_q;
  logic [15:0] pos_q;
  logic [15:0] neg_q;
  logic [31:0] rel_q;
  logic [31:0] now_q;
  logic [3:0]  full_q;
  logic [3:0]  zero_q;

  // Queue and drive state
  logic [tpd_pkg::SLOT_W-1:0] head_q [tpd_pkg::CHANNELS];
  logic [tpd_pkg::CNT_W-1:0]  cnt_q  [tpd_pkg::CHANNELS];
  logic                       drive_q;
  logic [31:0]                last_emit_q;
  logic [31:0]                lim_q;
  logic                       idle_q;

  // Result registers
  logic                valid_q;
  logic [2:0]          och_q;
  tpd_pkg::outcome_e   outc_q;
  logic [31:0]         word_q;
  logic                drive_out_q;
  logic                last_q;

  // Datapath
  logic [tpd_pkg::CH_W-1:0]   idx;
  logic [tpd_pkg::SLOT_W-1:0] head_cur;
  logic [tpd_pkg::CNT_W-1:0]  cnt_cur;
  logic                       enq_ok;
  logic [tpd_pkg::CNT_W:0]    tail_sum;
  logic [tpd_pkg::SLOT_W-1:0] tail;
  logic [tpd_pkg::SLOT_W-1:0] head_nxt;
  logic                       ram_we;
  logic [tpd_pkg::ADDR_W-1:0] ram_waddr;
  logic [tpd_pkg::ADDR_W-1:0] ram_raddr;
  logic [tpd_pkg::ENTRY_W-1:0] ram_wdata;
  logic [tpd_pkg::ENTRY_W-1:0] ram_rdata;
  logic [31:0]                ent_rel;
  logic [15:0]                ent_pos;
  logic [15:0]                ent_neg;
  logic [15:0]                pos_c;
  logic [15:0]                neg_c;
  logic                       is_last;
  logic                       pop;
  logic                       emit;
  tpd_pkg::outcome_e          ev_outcome;
  logic                       drive_d;
  logic [31:0]                ev_word;

  // Select the channel under service
  assign idx      = ch_q[tpd_pkg::CH_W-1:0];
  assign head_cur = head_q[idx];
  assign cnt_cur  = cnt_q[idx];
  assign is_last  = (32'(idx) == tpd_pkg::CHANNELS - 1);

  // Enqueue address: tail slot of the target channel
  assign enq_ok   = (32'(ch_q) < tpd_pkg::CHANNELS) &&
                    (32'(cnt_cur) < tpd_pkg::QUEUE_DEPTH);
  assign tail_sum = (tpd_pkg::CNT_W+1)'(head_cur) + (tpd_pkg::CNT_W+1)'(cnt_cur);
  assign tail     = (32'(tail_sum) >= tpd_pkg::QUEUE_DEPTH)
                    ? tpd_pkg::SLOT_W'(32'(tail_sum) - tpd_pkg::QUEUE_DEPTH)
                    : tpd_pkg::SLOT_W'(tail_sum);
  assign head_nxt = (32'(head_cur) == tpd_pkg::QUEUE_DEPTH - 1)
                    ? '0 : head_cur + tpd_pkg::SLOT_W'(1);

  assign ram_we    = (state_q == ST_ENQ) && enq_ok;
  assign ram_waddr = tpd_pkg::ADDR_W'(32'(idx) * tpd_pkg::QUEUE_DEPTH + 32'(tail));
  assign ram_wdata = {neg_q, pos_q, rel_q};
  assign ram_raddr = tpd_pkg::ADDR_W'(32'(idx) * tpd_pkg::QUEUE_DEPTH + 32'(head_cur));

  tpd_ram #(
    .Width (tpd_pkg::ENTRY_W),
    .Depth (tpd_pkg::STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Unpack the head entry and clamp its widths
  assign ent_rel = ram_rdata[31:0];
  assign ent_pos = ram_rdata[47:32];
  assign ent_neg = ram_rdata[63:48];
  assign pos_c   = (ent_pos > tpd_pkg::PW_MAX) ? tpd_pkg::PW_MAX : ent_pos;
  assign neg_c   = (ent_neg > tpd_pkg::PW_MAX) ? tpd_pkg::PW_MAX : ent_neg;

  // Evaluate the head of one channel during a tick
  always_comb begin
    pop        = 1'b0;
    emit       = 1'b0;
    ev_outcome = tpd_pkg::OUT_NONE;
    drive_d    = drive_q;
    ev_word    = '0;
    if (cnt_cur == '0) begin
      if (drive_q && idle_q) begin
        drive_d = 1'b0;
      end
    end else if (now_q >= ent_rel) begin
      pop = 1'b1;
      if (zero_q[idx] || !ready_q[idx] || (ent_rel > lim_q)) begin
        ev_outcome = tpd_pkg::OUT_DROP_NA;
      end else if (full_q[idx]) begin
        ev_outcome = tpd_pkg::OUT_DROP_FULL;
      end else begin
        emit       = 1'b1;
        ev_outcome = tpd_pkg::OUT_EMIT;
        ev_word    = (32'(pos_c) << tpd_pkg::WIDTH_BITS) | 32'(neg_c);
        if (!drive_q) begin
          drive_d = ((ready_q & tpd_pkg::ALL_READY) == tpd_pkg::ALL_READY);
        end
      end
    end
  end

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_q   <= '0;
      timeout_q <= tpd_pkg::RESET_IDLE_TIMEOUT;
      lead_q    <= tpd_pkg::RESET_MAX_LEAD;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tpd_pkg::REG_READY_MASK:   ready_q   <= cfg_data_i[3:0];
        tpd_pkg::REG_IDLE_TIMEOUT: timeout_q <= cfg_data_i;
        tpd_pkg::REG_MAX_LEAD:     lead_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer, queue state and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ch_q        <= '0;
      pos_q       <= '0;
      neg_q       <= '0;
      rel_q       <= '0;
      now_q       <= '0;
      full_q      <= '0;
      zero_q      <= '0;
      for (int i = 0; i < tpd_pkg::CHANNELS; i++) begin
        head_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
      drive_q     <= 1'b0;
      last_emit_q <= '0;
      lim_q       <= '0;
      idle_q      <= 1'b0;
      valid_q     <= 1'b0;
      och_q       <= '0;
      outc_q      <= tpd_pkg::OUT_NONE;
      word_q      <= '0;
      drive_out_q <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          // Latch the command word
          if (start_i) begin
            pos_q  <= pos_width_i;
            neg_q  <= neg_width_i;
            rel_q  <= release_time_i;
            now_q  <= now_us_i;
            full_q <= fifo_full_mask_i;
            zero_q <= zero_pending_mask_i;
            if (kind_i == tpd_pkg::KIND_ENQUEUE) begin
              ch_q    <= channel_i;
              state_q <= ST_ENQ;
            end else begin
              ch_q    <= '0;
              state_q <= ST_RD;
            end
          end
        end
        ST_ENQ: begin
          // Append to the tail, or reject
          if (enq_ok) begin
            cnt_q[idx] <= cnt_cur + tpd_pkg::CNT_W'(1);
            outc_q     <= tpd_pkg::OUT_ENQ;
          end else begin
            outc_q     <= tpd_pkg::OUT_REJECT;
          end
          valid_q     <= 1'b1;
          och_q       <= ch_q;
          word_q      <= '0;
          drive_out_q <= drive_q;
          last_q      <= 1'b1;
          state_q     <= ST_IDLE;
        end
        ST_RD: begin
          // Head read in flight; prepare the time limits
          lim_q   <= now_q + lead_q;
          idle_q  <= (now_q - last_emit_q) > timeout_q;
          state_q <= ST_EV;
        end
        ST_EV: begin
          // Drop, emit or keep the head, then advance to the next channel or go idle
          if (pop) begin
            head_q[idx] <= head_nxt;
            cnt_q[idx]  <= cnt_cur - tpd_pkg::CNT_W'(1);
          end
          if (emit) begin
            last_emit_q <= now_q;
          end
          drive_q     <= drive_d;
          valid_q     <= 1'b1;
          och_q       <= ch_q;
          outc_q      <= ev_outcome;
          word_q      <= ev_word;
          drive_out_q <= drive_d;
          last_q      <= is_last;
          if (is_last) begin
            state_q <= ST_IDLE;
          end else begin
            ch_q    <= ch_q + 3'd1;
            state_q <= ST_RD;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign result_valid_o = valid_q;
  assign out_channel_o  = och_q;
  assign outcome_o      = outc_q;
  assign pulse_word_o   = word_q;
  assign drive_enable_o = drive_out_q;
  assign last_o         = last_q;

endmodule

>>> hw/rtl/tpd_checker.sv
// ----------------------------------------------------------------------------
// tpd_checker
// Port-level checks of the timed pulse dispatcher, bound to the top level.
// ----------------------------------------------------------------------------
module tpd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        result_valid_o,
  input logic [2:0]  outcome_o,
  input logic [31:0] pulse_word_o,
  input logic        last_o
);

  // An accepted word always occupies the block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("accepted word did not raise busy");

  // The final word of an item is not followed directly by another word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_o |=> !result_valid_o)
    else $error("word directly after last word");

  // Enqueue outcomes are single-word items
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (outcome_o == tpd_pkg::OUT_ENQ || outcome_o == tpd_pkg::OUT_REJECT)
    |-> last_o)
    else $error("enqueue result not marked last");

  // Only an emitted pulse carries a pulse word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (outcome_o != tpd_pkg::OUT_EMIT) |-> (pulse_word_o == '0))
    else $error("pulse word set on a non-emit result");

  // A word shown while idle closes its item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !busy_o |-> last_o)
    else $error("block idle before last word");

endmodule

bind timed_pulse_dispatcher tpd_checker u_tpd_checker (.*);

>>> tb/sv/tb_timed_pulse_dispatcher.sv
// ----------------------------------------------------------------------------
// tb_timed_pulse_dispatcher
// Self-checking bench for the per-channel timed pulse queues and service tick.
// A scoreboard predicts every result word from the accepted command words and
// the register settings. A monitor compares each result as it appears. The
// stimulus runs a short directed pass over rejects, due boundaries, drops,
// lead wrap and idle timeout. It then runs random phases under several
// register settings, with one queue flooded past its depth and random gaps
// on the command side.
// ----------------------------------------------------------------------------
module tb_timed_pulse_dispatcher;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned SETTLE_CYCLES = 2 * tpd_pkg::CHANNELS + 2;
  localparam int unsigned PHASE_WORDS   = 40;
  localparam logic [1:0]  REG_UNUSED    = 2'd3;

  // One command word as driven on the command ports
  typedef struct {
    logic        kind;
    logic [2:0]  channel;
    logic [15:0] pos_width;
    logic [15:0] neg_width;
    logic [31:0] release_time;
    logic [31:0] now_us;
    logic [3:0]  full_mask;
    logic [3:0]  zero_mask;
  } cmd_word_t;

  // One queued pulse
  typedef struct {
    logic [31:0] release_at;
    logic [15:0] pos_width;
    logic [15:0] neg_width;
  } pulse_t;

  // One result word
  typedef struct {
    logic [2:0]        channel;
    tpd_pkg::outcome_e outcome;
    logic [31:0]       pulse_word;
    logic              drive;
    logic              last;
  } dispatch_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: predicts the dispatch results and checks them in order
  // --------------------------------------------------------------------------
  class dispatch_scoreboard;
    pulse_t           pulse_queue[tpd_pkg::CHANNELS][$];
    dispatch_result_t expected[$];
    logic [3:0]       ready_mask;
    logic [31:0]      idle_timeout;
    logic [31:0]      max_lead;
    logic             drive_on;
    logic [31:0]      last_emit;
    int unsigned      failures;
    int unsigned      n_enqueue, n_reject, n_tick, n_emit, n_drop_na, n_drop_full;
    int unsigned      n_checked;

    function new();
      ready_mask   = '0;
      idle_timeout = tpd_pkg::RESET_IDLE_TIMEOUT;
      max_lead     = tpd_pkg::RESET_MAX_LEAD;
      drive_on     = 1'b0;
      last_emit    = '0;
    endfunction

    function void set_register(logic [1:0] idx, logic [31:0] data);
      case (idx)
        tpd_pkg::REG_READY_MASK:   ready_mask   = data[3:0];
        tpd_pkg::REG_IDLE_TIMEOUT: idle_timeout = data;
        tpd_pkg::REG_MAX_LEAD:     max_lead     = data;
        default: ;
      endcase
    endfunction

    function void queue_result(logic [2:0] ch, tpd_pkg::outcome_e oc, logic [31:0] word,
                               logic last);
      dispatch_result_t r;
      r.channel    = ch;
      r.outcome    = oc;
      r.pulse_word = word;
      r.drive      = drive_on;
      r.last       = last;
      expected.push_back(r);
    endfunction

    // Work out the results of one accepted command word
    function void note_word(cmd_word_t w);
      pulse_t      head;
      logic        last;
      logic [15:0] pos;
      logic [15:0] neg;
      int          c;
      if (w.kind == tpd_pkg::KIND_ENQUEUE) begin
        n_enqueue++;
        if (w.channel >= tpd_pkg::CHANNELS ||
            pulse_queue[w.channel].size() >= tpd_pkg::QUEUE_DEPTH) begin
          n_reject++;
          queue_result(w.channel, tpd_pkg::OUT_REJECT, '0, 1'b1);
        end else begin
          head.release_at = w.release_time;
          head.pos_width  = w.pos_width;
          head.neg_width  = w.neg_width;
          pulse_queue[w.channel].push_back(head);
          queue_result(w.channel, tpd_pkg::OUT_ENQ, '0, 1'b1);
        end
        return;
      end
      n_tick++;
      for (c = 0; c < tpd_pkg::CHANNELS; c++) begin
        last = (c == tpd_pkg::CHANNELS - 1);
        // Empty queue: drop the drive once idle past the timeout
        if (pulse_queue[c].size() == 0) begin
          if (drive_on && (w.now_us - last_emit) > idle_timeout) drive_on = 1'b0;
          queue_result(3'(c), tpd_pkg::OUT_NONE, '0, last);
          continue;
        end
        head = pulse_queue[c][0];
        if (w.now_us < head.release_at) begin
          queue_result(3'(c), tpd_pkg::OUT_NONE, '0, last);
          continue;
        end
        void'(pulse_queue[c].pop_front());
        if (w.zero_mask[c] || !ready_mask[c] || head.release_at > w.now_us + max_lead) begin
          n_drop_na++;
          queue_result(3'(c), tpd_pkg::OUT_DROP_NA, '0, last);
        end else if (w.full_mask[c]) begin
          n_drop_full++;
          queue_result(3'(c), tpd_pkg::OUT_DROP_FULL, '0, last);
        end else begin
          // Clamp widths, note the emit time, power up only when all are ready
          pos = (head.pos_width > tpd_pkg::PW_MAX) ? tpd_pkg::PW_MAX : head.pos_width;
          neg = (head.neg_width > tpd_pkg::PW_MAX) ? tpd_pkg::PW_MAX : head.neg_width;
          last_emit = w.now_us;
          if (!drive_on) begin
            drive_on = ((ready_mask & tpd_pkg::ALL_READY) == tpd_pkg::ALL_READY);
          end
          n_emit++;
          queue_result(3'(c), tpd_pkg::OUT_EMIT,
                       (32'(pos) << tpd_pkg::WIDTH_BITS) | 32'(neg), last);
        end
      end
    endfunction

    function void check_result(logic [2:0] ch, logic [2:0] oc, logic [31:0] word,
                               logic drive, logic last);
      dispatch_result_t e;
      if (expected.size() == 0) begin
        $error("result word on channel %0d with none outstanding", ch);
        failures++;
        return;
      end
      e = expected.pop_front();
      n_checked++;
      if (ch !== e.channel) begin
        $error("out_channel: expected %0d, actual %0d", e.channel, ch);
        failures++;
      end
      if (oc !== e.outcome) begin
        $error("outcome: expected %0d, actual %0d", e.outcome, oc);
        failures++;
      end
      if (word !== e.pulse_word) begin
        $error("pulse_word: expected %h, actual %h", e.pulse_word, word);
        failures++;
      end
      if (drive !== e.drive) begin
        $error("drive_enable: expected %0b, actual %0b", e.drive, drive);
        failures++;
      end
      if (last !== e.last) begin
        $error("last: expected %0b, actual %0b", e.last, last);
        failures++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block
  // --------------------------------------------------------------------------
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic        kind_i = 1'b0;
  logic [2:0]  channel_i = '0;
  logic [15:0] pos_width_i = '0;
  logic [15:0] neg_width_i = '0;
  logic [31:0] release_time_i = '0;
  logic [31:0] now_us_i = '0;
  logic [3:0]  fifo_full_mask_i = '0;
  logic [3:0]  zero_pending_mask_i = '0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        result_valid_o;
  logic [2:0]  out_channel_o;
  logic [2:0]  outcome_o;
  logic [31:0] pulse_word_o;
  logic        drive_enable_o;
  logic        last_o;

  dispatch_scoreboard sb = new();
  int unsigned        cycle_count = 0;
  logic [31:0]        clock_us = '0;
  logic               quiet_stretch = 1'b0;

  always #10 clk_i = ~clk_i;

  timed_pulse_dispatcher u_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start_i             (start_i),
    .busy_o              (busy_o),
    .kind_i              (kind_i),
    .channel_i           (channel_i),
    .pos_width_i         (pos_width_i),
    .neg_width_i         (neg_width_i),
    .release_time_i      (release_time_i),
    .now_us_i            (now_us_i),
    .fifo_full_mask_i    (fifo_full_mask_i),
    .zero_pending_mask_i (zero_pending_mask_i),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_data_i          (cfg_data_i),
    .result_valid_o      (result_valid_o),
    .out_channel_o       (out_channel_o),
    .outcome_o           (outcome_o),
    .pulse_word_o        (pulse_word_o),
    .drive_enable_o      (drive_enable_o),
    .last_o              (last_o)
  );

  // Check each result word at the edge that ends its cycle
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      sb.check_result(out_channel_o, outcome_o, pulse_word_o, drive_enable_o, last_o);
    end
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               sb.expected.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Word builders
  // --------------------------------------------------------------------------
  function automatic cmd_word_t noise_fields();
    cmd_word_t w;
    w.kind         = 1'($urandom);
    w.channel      = 3'($urandom);
    w.pos_width    = 16'($urandom);
    w.neg_width    = 16'($urandom);
    w.release_time = $urandom;
    w.now_us       = $urandom;
    w.full_mask    = 4'($urandom);
    w.zero_mask    = 4'($urandom);
    return w;
  endfunction

  function automatic cmd_word_t enqueue_word(logic [2:0] ch, logic [15:0] pos,
                                             logic [15:0] neg, logic [31:0] rel);
    cmd_word_t w;
    w = noise_fields();
    w.kind         = tpd_pkg::KIND_ENQUEUE;
    w.channel      = ch;
    w.pos_width    = pos;
    w.neg_width    = neg;
    w.release_time = rel;
    return w;
  endfunction

  function automatic cmd_word_t tick_word(logic [31:0] now, logic [3:0] full,
                                          logic [3:0] zero);
    cmd_word_t w;
    w = noise_fields();
    w.kind      = tpd_pkg::KIND_TICK;
    w.now_us    = now;
    w.full_mask = full;
    w.zero_mask = zero;
    return w;
  endfunction

  // Mostly pulses near the running time and ticks that advance it, some noise
  function automatic cmd_word_t random_word();
    int unsigned roll;
    logic [3:0]  full;
    logic [3:0]  zero;
    roll = $urandom_range(0, 99);
    full = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'b0000;
    zero = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'b0000;
    if (roll < 50) begin
      return enqueue_word(3'($urandom_range(0, tpd_pkg::CHANNELS - 1)), 16'($urandom),
                          16'($urandom), clock_us + $urandom_range(0, 60) - 32'd10);
    end else if (roll < 85) begin
      clock_us = clock_us + $urandom_range(0, 40);
      return tick_word(clock_us, full, zero);
    end else if (roll < 92) begin
      return enqueue_word(3'($urandom), 16'($urandom), 16'($urandom), $urandom);
    end
    return tick_word($urandom, 4'($urandom), 4'($urandom));
  endfunction

  function automatic int unsigned draw_gap();
    if ($urandom_range(0, 11) == 0) quiet_stretch = ~quiet_stretch;
    return quiet_stretch ? 0 : $urandom_range(0, 17);
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // Hold a word on the command ports until the block takes it
  task automatic send_word(input cmd_word_t w);
    int unsigned gap;
    gap = draw_gap();
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    kind_i              <= w.kind;
    channel_i           <= w.channel;
    pos_width_i         <= w.pos_width;
    neg_width_i         <= w.neg_width;
    release_time_i      <= w.release_time;
    now_us_i            <= w.now_us;
    fifo_full_mask_i    <= w.full_mask;
    zero_pending_mask_i <= w.zero_mask;
    start_i             <= 1'b1;
    do @(posedge clk_i); while (busy_o);
    sb.note_word(w);
  endtask

  // Drop start and wait until every result word is in
  task automatic settle();
    start_i <= 1'b0;
    while (sb.expected.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.set_register(idx, data);
  endtask

  task automatic configure(input logic [3:0] ready, input logic [31:0] timeout,
                           input logic [31:0] lead);
    write_reg(tpd_pkg::REG_READY_MASK, 32'(ready));
    write_reg(tpd_pkg::REG_IDLE_TIMEOUT, timeout);
    write_reg(tpd_pkg::REG_MAX_LEAD, lead);
    write_reg(REG_UNUSED, $urandom);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_phase(input int unsigned count);
    repeat (count) send_word(random_word());
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    logic [2:0] flood_ch;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: rejects, not due, due at the boundary but not ready
    send_word(tick_word(32'd0, 4'b0000, 4'b0000));
    send_word(enqueue_word(3'd7, 16'h1234, 16'h4321, 32'd0));
    send_word(enqueue_word(3'd4, 16'h0001, 16'h0002, 32'd0));
    send_word(enqueue_word(3'd0, 16'h0001, 16'h0002, 32'd5));
    send_word(tick_word(32'd4, 4'b0000, 4'b0000));
    send_word(tick_word(32'd5, 4'b0000, 4'b0000));
    settle();

    // All ready: emit, generator full, zeroing pending, idle timeout edge
    configure(4'b1111, 32'd100, 32'hFFFF_FFFF);
    send_word(enqueue_word(3'd0, 16'hFFFF, 16'h0000, 32'd10));
    send_word(enqueue_word(3'd1, 16'h0000, 16'hFFFF, 32'd10));
    send_word(enqueue_word(3'd2, 16'hAAAA, 16'h5555, 32'd10));
    send_word(enqueue_word(3'd3, 16'h5555, 16'hAAAA, 32'd10));
    send_word(tick_word(32'd10, 4'b0100, 4'b1000));
    send_word(tick_word(32'd110, 4'b0000, 4'b0000));
    send_word(tick_word(32'd111, 4'b0000, 4'b0000));
    // Lead window wraps: the pulse due exactly now lies past now + lead
    send_word(enqueue_word(3'd0, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFF0));
    send_word(enqueue_word(3'd1, 16'h8001, 16'h7FFE, 32'hFFFF_FFFF));
    send_word(tick_word(32'hFFFF_FFFF, 4'b0000, 4'b0000));
    settle();

    // Partly ready, zero timeout and lead: drive drops and stays off on emit
    configure(4'b0101, 32'd0, 32'd0);
    send_word(enqueue_word(3'd2, 16'h0F0F, 16'hF0F0, 32'd100));
    send_word(enqueue_word(3'd1, 16'h00FF, 16'hFF00, 32'd0));
    send_word(tick_word(32'd200, 4'b0000, 4'b0000));
    send_word(tick_word(32'd200, 4'b1111, 4'b1111));
    settle();

    configure(4'b1111, $urandom_range(0, 300), $urandom_range(0, 100));
    clock_us = $urandom;
    random_phase(PHASE_WORDS);
    settle();

    // Overfill one queue, then keep going with it backed up
    configure(4'($urandom), 32'd0, 32'd0);
    flood_ch = 3'($urandom_range(0, tpd_pkg::CHANNELS - 1));
    repeat (tpd_pkg::QUEUE_DEPTH + 3) begin
      send_word(enqueue_word(flood_ch, 16'($urandom), 16'($urandom),
                             clock_us + $urandom_range(0, 60)));
    end
    random_phase(PHASE_WORDS - 15);
    settle();

    // Widest timeout and lead, with the running time crossing the wrap
    configure(4'b1111, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    clock_us = 32'hFFFF_FF00;
    random_phase(PHASE_WORDS);
    settle();

    configure(4'($urandom), $urandom_range(0, 100), $urandom);
    clock_us = $urandom;
    random_phase(PHASE_WORDS);
    settle();

    configure(4'b1111, 32'd50, 32'd1000);
    random_phase(PHASE_WORDS);
    settle();

    $display("Ran %0d enqueues (%0d rejected) and %0d ticks, %0d results checked",
             sb.n_enqueue, sb.n_reject, sb.n_tick, sb.n_checked);
    $display("Pulses: %0d emitted, %0d dropped not allowed, %0d dropped on full generator",
             sb.n_emit, sb.n_drop_na, sb.n_drop_full);
    if (sb.failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
